[sv/ucfp_pkg.sv]
// Shared types and constants for the serial command frame parser.
// No dependencies.
package ucfp_pkg;

	localparam logic [7:0] TYPE_SNAP  = 8'h00;
	localparam logic [7:0] TYPE_READ  = 8'h02;
	localparam logic [7:0] TYPE_CLOCK = 8'h04;

	localparam int HDR_LEN_BYTES = 2;
	localparam int RD_OFS_BYTES  = 4;
	localparam int RD_CNT_BYTES  = 2;
	localparam int CLK_BYTES     = 7;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_LEN     = 3'd1,
		PH_FMT     = 3'd2,
		PH_SNAPSUM = 3'd3,
		PH_RDHDR   = 3'd4,
		PH_NAME    = 3'd5,
		PH_RDSUM   = 3'd6,
		PH_CLOCK   = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		EV_NAME  = 2'd0,
		EV_SNAP  = 2'd1,
		EV_READ  = 2'd2,
		EV_CLOCK = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CSUM    = 2'd1,
		ST_LEN     = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [1:0]  status;
		logic [7:0]  data_byte;
		logic [31:0] file_offset;
		logic [15:0] read_length;
		logic [15:0] year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
	} result_t;

endpackage

[sv/ucfp_rx_if.sv]
// Receive byte channel: valid/ready handshake carrying one serial byte.
// No dependencies.
interface ucfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

[sv/ucfp_res_if.sv]
// Result channel: valid/ready handshake carrying one parser event.
// No dependencies.
interface ucfp_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic [1:0]  status;
	logic [7:0]  data_byte;
	logic [31:0] file_offset;
	logic [15:0] read_length;
	logic [15:0] year;
	logic [7:0]  month;
	logic [7:0]  day;
	logic [7:0]  hour;
	logic [7:0]  minute;
	logic [7:0]  second;

	modport source (output valid, output event_res, output status, output data_byte,
		output file_offset, output read_length, output year, output month, output day,
		output hour, output minute, output second, input ready);
	modport sink (input valid, input event_res, input status, input data_byte,
		input file_offset, input read_length, input year, input month, input day,
		input hour, input minute, input second, output ready);
endinterface

[sv/ucfp_core.sv]
// Frame state machine: one accepted byte per cycle while beat is high, at most one result per byte.
// Depends on ucfp_pkg.
module ucfp_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               beat,
	input  logic [7:0]         rx_byte,
	output logic               res_valid,
	output ucfp_pkg::result_t  res
);
	import ucfp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  mtype_q, mtype_d;
	logic [7:0]  len_lo_q, len_lo_d;
	logic [7:0]  fmt_q, fmt_d;
	logic [31:0] ofs_q, ofs_d;
	logic [15:0] rlen_q, rlen_d;
	logic [7:0]  nlen_q, nlen_d;
	logic [55:0] clk_q, clk_d;
	logic [8:0]  count_inc;
	logic [7:0]  sum_add;

	assign count_inc = {1'b0, count_q} + 9'd1;
	assign sum_add   = sum_q + rx_byte;

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		sum_d     = sum_q;
		mtype_d   = mtype_q;
		len_lo_d  = len_lo_q;
		fmt_d     = fmt_q;
		ofs_d     = ofs_q;
		rlen_d    = rlen_q;
		nlen_d    = nlen_q;
		clk_d     = clk_q;
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == TYPE_SNAP || rx_byte == TYPE_READ || rx_byte == TYPE_CLOCK) begin
					mtype_d = rx_byte;
					sum_d   = (rx_byte == TYPE_SNAP) ? 8'd0 : rx_byte;
					count_d = '0;
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				sum_d = sum_add;
				if (count_q == 8'd0)
					len_lo_d = rx_byte;
				count_d = count_inc[7:0];
				if (count_inc >= 9'(HDR_LEN_BYTES)) begin
					count_d = '0;
					if (mtype_q == TYPE_SNAP)
						phase_d = PH_FMT;
					else if (mtype_q == TYPE_READ)
						phase_d = PH_RDHDR;
					else
						phase_d = PH_CLOCK;
				end
			end
			PH_FMT: begin
				fmt_d   = rx_byte;
				sum_d   = sum_add;
				phase_d = PH_SNAPSUM;
			end
			PH_SNAPSUM: begin
				res_valid     = 1'b1;
				res.event_res = EV_SNAP;
				// length error wins over a bad checksum
				if (len_lo_q == 8'd0)
					res.status = ST_LEN;
				else if (sum_q != rx_byte)
					res.status = ST_CSUM;
				else
					res.status = ST_OK;
				res.data_byte = fmt_q;
				phase_d       = PH_HUNT;
			end
			PH_RDHDR: begin
				sum_d = sum_add;
				if (count_q < 8'(RD_OFS_BYTES))
					ofs_d = {rx_byte, ofs_q[31:8]};
				else if (count_q < 8'(RD_OFS_BYTES + RD_CNT_BYTES))
					rlen_d = {rx_byte, rlen_q[15:8]};
				else
					nlen_d = rx_byte;
				count_d = count_inc[7:0];
				if (count_inc > 9'(RD_OFS_BYTES + RD_CNT_BYTES)) begin
					count_d = '0;
					phase_d = PH_NAME;
				end
			end
			PH_NAME: begin
				// empty name still eats one byte, left out of the sum
				if (nlen_q != 8'd0)
					sum_d = sum_add;
				res_valid     = 1'b1;
				res.event_res = EV_NAME;
				res.status    = ST_OK;
				res.data_byte = rx_byte;
				count_d       = count_inc[7:0];
				if (count_inc >= {1'b0, nlen_q}) begin
					count_d = '0;
					phase_d = PH_RDSUM;
				end
			end
			PH_RDSUM: begin
				res_valid       = 1'b1;
				res.event_res   = EV_READ;
				res.status      = (sum_q == rx_byte) ? ST_OK : ST_CSUM;
				res.file_offset = ofs_q;
				res.read_length = rlen_q;
				phase_d         = PH_HUNT;
			end
			PH_CLOCK: begin
				if (count_q < 8'(CLK_BYTES)) begin
					sum_d   = sum_add;
					clk_d   = {rx_byte, clk_q[55:8]};
					count_d = count_inc[7:0];
				end else begin
					res_valid     = 1'b1;
					res.event_res = EV_CLOCK;
					res.status    = (sum_q == rx_byte) ? ST_OK : ST_CSUM;
					res.year      = clk_q[15:0];
					res.month     = clk_q[23:16];
					res.day       = clk_q[31:24];
					res.hour      = clk_q[39:32];
					res.minute    = clk_q[47:40];
					res.second    = clk_q[55:48];
					count_d       = '0;
					phase_d       = PH_HUNT;
				end
			end
			default: phase_d = PH_HUNT;
		endcase
		if (!beat)
			res_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			count_q  <= '0;
			sum_q    <= '0;
			mtype_q  <= '0;
			len_lo_q <= '0;
			fmt_q    <= '0;
			ofs_q    <= '0;
			rlen_q   <= '0;
			nlen_q   <= '0;
			clk_q    <= '0;
		end else if (beat) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			sum_q    <= sum_d;
			mtype_q  <= mtype_d;
			len_lo_q <= len_lo_d;
			fmt_q    <= fmt_d;
			ofs_q    <= ofs_d;
			rlen_q   <= rlen_d;
			nlen_q   <= nlen_d;
			clk_q    <= clk_d;
		end
	end

endmodule

[sv/uart_command_frame_parser.sv]
// Top level of the serial command frame parser: frame state machine plus result queue.
// Depends on ucfp_pkg, ucfp_rx_if, ucfp_res_if and ucfp_core.
//
// Takes one received serial byte per beat on rx and deframes snap (type 0x00),
// read (type 0x02) and clock (type 0x04) frames, each a type byte, two length
// bytes, a body and an 8-bit additive checksum. Bytes that are not a known type
// are dropped while hunting. A completed frame gives one result beat on res; each
// name byte of a read frame gives one name-byte beat as it arrives. Rate: one byte
// per cycle, sustained while a queue entry is free. The frame state and running
// checksum update in the same cycle a byte is taken, and the result lands in a
// two-entry output queue, so rx stays ready while one result waits; rx only stalls
// once both entries are held. Results reach res through the registered queue.
module uart_command_frame_parser (
	input logic       clk,
	input logic       arst_n,
	ucfp_rx_if.sink   rx,
	ucfp_res_if.source res
);
	import ucfp_pkg::*;

	logic    beat_in;
	logic    core_valid;
	result_t core_res;
	logic    pop;

	// two-entry queue: head drives res, tail absorbs a result while res stalls
	result_t    head_q, tail_q;
	logic [1:0] cnt_q;

	assign rx.ready = (cnt_q != 2'd2);
	assign beat_in  = rx.valid & rx.ready;
	assign pop      = res.valid & res.ready;

	ucfp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat_in),
		.rx_byte   (rx.rx_byte),
		.res_valid (core_valid),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({core_valid, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		case ({core_valid, pop})
			2'b11: begin
				if (cnt_q == 2'd2) begin
					head_q <= tail_q;
					tail_q <= core_res;
				end else begin
					head_q <= core_res;
				end
			end
			2'b10: begin
				if (cnt_q == 2'd0)
					head_q <= core_res;
				else
					tail_q <= core_res;
			end
			2'b01: begin
				head_q <= tail_q;
			end
			default: head_q <= head_q;
		endcase
	end

	assign res.valid       = (cnt_q != 2'd0);
	assign res.event_res   = head_q.event_res;
	assign res.status      = head_q.status;
	assign res.data_byte   = head_q.data_byte;
	assign res.file_offset = head_q.file_offset;
	assign res.read_length = head_q.read_length;
	assign res.year        = head_q.year;
	assign res.month       = head_q.month;
	assign res.day         = head_q.day;
	assign res.hour        = head_q.hour;
	assign res.minute      = head_q.minute;
	assign res.second      = head_q.second;

endmodule

[tb/sv/uart_command_frame_parser_tb.sv]
// Self-checking testbench for uart_command_frame_parser: directed and random frames.
// Depends on ucfp_pkg, ucfp_rx_if, ucfp_res_if and the parser RTL.
`timescale 1ns / 1ps

module uart_command_frame_parser_tb;
	import ucfp_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	ucfp_rx_if  rx_ch ();
	ucfp_res_if res_ch ();

	uart_command_frame_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch.sink),
		.res    (res_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Parser mirror: our own copy of the deframing state
	phase_t      frame_phase;
	logic [7:0]  field_cnt;
	logic [7:0]  csum;
	logic [7:0]  frame_type;
	logic [7:0]  len_lo;
	logic [7:0]  fmt_byte;
	logic [31:0] ofs_acc;
	logic [15:0] cnt_acc;
	logic [7:0]  name_len;
	logic [55:0] clk_acc;

	// Events the parser owes us, oldest first
	result_t parser_events_due[$];

	// Frame under construction and its running sum
	logic [7:0] frame_buf[$];
	logic [7:0] frame_sum;

	bit rx_gaps_on;
	bit res_stalls_on;
	int stall_left;

	int mismatches;
	int beats_sent;
	int events_checked;
	int event_tally[4];
	int csum_err_tally;
	int len_err_tally;

	result_t seen_event;
	result_t want_event;
	string   field_diffs;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 60)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// One received byte through the frame state machine; queues any event it causes
	task automatic deframe_byte(input logic [7:0] b);
		result_t r;
		r = '0;
		case (frame_phase)
			PH_HUNT: begin
				// anything but a known type byte is dropped silently
				if (b == TYPE_SNAP || b == TYPE_READ || b == TYPE_CLOCK) begin
					frame_type = b;
					csum = (b == TYPE_SNAP) ? 8'h00 : b;
					field_cnt = 8'd0;
					frame_phase = PH_LEN;
				end
			end
			PH_LEN: begin
				csum = csum + b;
				if (field_cnt == 8'd0)
					len_lo = b;
				field_cnt = field_cnt + 8'd1;
				if (field_cnt >= HDR_LEN_BYTES) begin
					field_cnt = 8'd0;
					if (frame_type == TYPE_SNAP)
						frame_phase = PH_FMT;
					else if (frame_type == TYPE_READ)
						frame_phase = PH_RDHDR;
					else
						frame_phase = PH_CLOCK;
				end
			end
			PH_FMT: begin
				fmt_byte = b;
				csum = csum + b;
				frame_phase = PH_SNAPSUM;
			end
			PH_SNAPSUM: begin
				// a zero low length byte wins over a bad sum
				r.event_res = EV_SNAP;
				if (len_lo == 8'd0)
					r.status = ST_LEN;
				else if (csum != b)
					r.status = ST_CSUM;
				else
					r.status = ST_OK;
				r.data_byte = fmt_byte;
				parser_events_due.push_back(r);
				frame_phase = PH_HUNT;
			end
			PH_RDHDR: begin
				csum = csum + b;
				if (field_cnt < RD_OFS_BYTES)
					ofs_acc = {b, ofs_acc[31:8]};
				else if (field_cnt < RD_OFS_BYTES + RD_CNT_BYTES)
					cnt_acc = {b, cnt_acc[15:8]};
				else
					name_len = b;
				field_cnt = field_cnt + 8'd1;
				if (field_cnt > RD_OFS_BYTES + RD_CNT_BYTES) begin
					field_cnt = 8'd0;
					frame_phase = PH_NAME;
				end
			end
			PH_NAME: begin
				// empty name still eats one byte, left out of the sum
				if (name_len != 8'd0)
					csum = csum + b;
				r.event_res = EV_NAME;
				r.status = ST_OK;
				r.data_byte = b;
				parser_events_due.push_back(r);
				field_cnt = field_cnt + 8'd1;
				if (field_cnt >= name_len) begin
					field_cnt = 8'd0;
					frame_phase = PH_RDSUM;
				end
			end
			PH_RDSUM: begin
				r.event_res = EV_READ;
				r.status = (csum == b) ? ST_OK : ST_CSUM;
				r.file_offset = ofs_acc;
				r.read_length = cnt_acc;
				parser_events_due.push_back(r);
				frame_phase = PH_HUNT;
			end
			PH_CLOCK: begin
				if (field_cnt < CLK_BYTES) begin
					csum = csum + b;
					clk_acc = {b, clk_acc[55:8]};
					field_cnt = field_cnt + 8'd1;
				end else begin
					r.event_res = EV_CLOCK;
					r.status = (csum == b) ? ST_OK : ST_CSUM;
					r.year = clk_acc[15:0];
					r.month = clk_acc[23:16];
					r.day = clk_acc[31:24];
					r.hour = clk_acc[39:32];
					r.minute = clk_acc[47:40];
					r.second = clk_acc[55:48];
					parser_events_due.push_back(r);
					field_cnt = 8'd0;
					frame_phase = PH_HUNT;
				end
			end
			default: frame_phase = PH_HUNT;
		endcase
	endtask

	// One byte beat on rx, with an optional idle burst in front of it
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		beats_sent++;
		deframe_byte(b);
	endtask

	task automatic put_byte(input logic [7:0] b, input bit summed);
		frame_buf.push_back(b);
		if (summed)
			frame_sum = frame_sum + b;
	endtask

	task automatic put_sum(input bit bad_sum);
		if (bad_sum)
			frame_buf.push_back(frame_sum ^ 8'($urandom_range(1, 255)));
		else
			frame_buf.push_back(frame_sum);
	endtask

	task automatic send_frame();
		foreach (frame_buf[i])
			send_byte(frame_buf[i]);
		frame_buf.delete();
	endtask

	// Snap: type byte kept out of the sum
	task automatic build_snap(input logic [7:0] l_lo, input logic [7:0] l_hi,
		input logic [7:0] fmt, input bit bad_sum);
		frame_sum = 8'h00;
		put_byte(TYPE_SNAP, 1'b0);
		put_byte(l_lo, 1'b1);
		put_byte(l_hi, 1'b1);
		put_byte(fmt, 1'b1);
		put_sum(bad_sum);
	endtask

	task automatic build_read(input logic [31:0] ofs, input logic [15:0] cnt,
		input logic [7:0] nlen, input bit bad_sum);
		frame_sum = 8'h00;
		put_byte(TYPE_READ, 1'b1);
		put_byte(8'($urandom), 1'b1);
		put_byte(8'($urandom), 1'b1);
		for (int i = 0; i < 4; i++)
			put_byte(ofs[8*i +: 8], 1'b1);
		put_byte(cnt[7:0], 1'b1);
		put_byte(cnt[15:8], 1'b1);
		put_byte(nlen, 1'b1);
		if (nlen == 8'd0)
			put_byte(8'($urandom), 1'b0);
		else
			for (int i = 0; i < nlen; i++)
				put_byte(8'($urandom), 1'b1);
		put_sum(bad_sum);
	endtask

	task automatic build_clock(input logic [55:0] stamp, input bit bad_sum);
		frame_sum = 8'h00;
		put_byte(TYPE_CLOCK, 1'b1);
		put_byte(8'($urandom), 1'b1);
		put_byte(8'($urandom), 1'b1);
		for (int i = 0; i < 7; i++)
			put_byte(stamp[8*i +: 8], 1'b1);
		put_sum(bad_sum);
	endtask

	// Mostly well-formed frames with random content; some noise and cut-short frames
	task automatic random_frame();
		int pick;
		int cut;
		int nl_pick;
		logic [7:0] nlen;
		pick = $urandom_range(0, 19);
		if (pick == 18) begin
			repeat ($urandom_range(1, 6))
				send_byte(8'($urandom));
			return;
		end
		if (pick < 6 || pick == 19) begin
			build_snap(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom),
				8'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
		end else if (pick < 13) begin
			nl_pick = $urandom_range(0, 9);
			if (nl_pick == 0)
				nlen = 8'd0;
			else if (nl_pick == 1)
				nlen = 8'($urandom_range(9, 40));
			else
				nlen = 8'($urandom_range(1, 8));
			build_read($urandom, 16'($urandom), nlen, $urandom_range(0, 3) == 0);
		end else begin
			build_clock(56'({$urandom, $urandom}), $urandom_range(0, 3) == 0);
		end
		if (pick == 19 || (pick < 18 && $urandom_range(0, 15) == 0)) begin
			// cut the tail off so the next frame lands mid-parse
			cut = $urandom_range(1, frame_buf.size() - 1);
			repeat (cut)
				void'(frame_buf.pop_back());
		end
		send_frame();
	endtask

	// Result side: random stall bursts on ready
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (res_stalls_on && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(1, 5) - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	task automatic diff_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			field_diffs = {field_diffs, $sformatf(" %s=%0h(want %0h)", name, got, want)};
	endtask

	// Every result beat checked against the oldest outstanding event
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			seen_event.event_res = res_ch.event_res;
			seen_event.status = res_ch.status;
			seen_event.data_byte = res_ch.data_byte;
			seen_event.file_offset = res_ch.file_offset;
			seen_event.read_length = res_ch.read_length;
			seen_event.year = res_ch.year;
			seen_event.month = res_ch.month;
			seen_event.day = res_ch.day;
			seen_event.hour = res_ch.hour;
			seen_event.minute = res_ch.minute;
			seen_event.second = res_ch.second;
			if (parser_events_due.size() == 0) begin
				report_mismatch($sformatf("result beat with none outstanding, event %0d",
					seen_event.event_res));
			end else begin
				want_event = parser_events_due.pop_front();
				field_diffs = "";
				diff_field("event", 32'(seen_event.event_res), 32'(want_event.event_res));
				diff_field("status", 32'(seen_event.status), 32'(want_event.status));
				diff_field("data", 32'(seen_event.data_byte), 32'(want_event.data_byte));
				diff_field("offset", seen_event.file_offset, want_event.file_offset);
				diff_field("length", 32'(seen_event.read_length),
					32'(want_event.read_length));
				diff_field("year", 32'(seen_event.year), 32'(want_event.year));
				diff_field("month", 32'(seen_event.month), 32'(want_event.month));
				diff_field("day", 32'(seen_event.day), 32'(want_event.day));
				diff_field("hour", 32'(seen_event.hour), 32'(want_event.hour));
				diff_field("minute", 32'(seen_event.minute), 32'(want_event.minute));
				diff_field("second", 32'(seen_event.second), 32'(want_event.second));
				if (field_diffs != "")
					report_mismatch($sformatf("result %0d:%s", events_checked, field_diffs));
				events_checked++;
				event_tally[want_event.event_res]++;
				if (want_event.status == ST_CSUM)
					csum_err_tally++;
				if (want_event.status == ST_LEN)
					len_err_tally++;
			end
		end
	end

	// Directed: bytes that are not a type byte, including neighbours of real types
	task automatic test_unknown_types();
		send_byte(8'h01);
		send_byte(8'hFF);
		send_byte(8'h03);
	endtask

	// Directed: zero low length with a correct sum still reports a length error
	task automatic test_snap_length_error();
		build_snap(8'h00, 8'hFF, 8'hFF, 1'b0);
		send_frame();
	endtask

	// Directed: all-ones offset and length, empty name that still takes one byte
	task automatic test_read_empty_name();
		build_read(32'hFFFF_FFFF, 16'hFFFF, 8'd0, 1'b0);
		send_frame();
	endtask

	// Directed: clock frame with a bad sum still carries its fields
	task automatic test_clock_bad_checksum();
		build_clock(56'hFF_00FF_00FF_00FF, 1'b1);
		send_frame();
	endtask

	// Random traffic with idle and stall bursts switching on and off
	task automatic test_random_frames(input int byte_budget);
		int start;
		start = beats_sent;
		while (beats_sent - start < byte_budget) begin
			if ($urandom_range(0, 7) == 0)
				rx_gaps_on = !rx_gaps_on;
			if ($urandom_range(0, 7) == 0)
				res_stalls_on = !res_stalls_on;
			random_frame();
		end
	endtask

	// Largest name: 255 name bytes, one event each
	task automatic test_long_name();
		rx_gaps_on = 1'b1;
		res_stalls_on = 1'b1;
		build_read($urandom, 16'($urandom), 8'd255, 1'b0);
		send_frame();
	endtask

	task automatic test_random_frames_flat(input int byte_budget);
		int start;
		start = beats_sent;
		while (beats_sent - start < byte_budget)
			random_frame();
	endtask

	// Final stretch at full rate on both sides
	task automatic test_back_to_back(input int byte_budget);
		rx_gaps_on = 1'b0;
		res_stalls_on = 1'b0;
		test_random_frames_flat(byte_budget);
	endtask

	initial begin
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		res_ch.ready = 1'b0;
		stall_left = 0;
		rx_gaps_on = 1'b1;
		res_stalls_on = 1'b1;
		mismatches = 0;
		beats_sent = 0;
		events_checked = 0;
		csum_err_tally = 0;
		len_err_tally = 0;
		foreach (event_tally[i])
			event_tally[i] = 0;
		frame_phase = PH_HUNT;
		field_cnt = 8'd0;
		csum = 8'd0;
		frame_type = 8'd0;
		len_lo = 8'd0;
		fmt_byte = 8'd0;
		ofs_acc = 32'd0;
		cnt_acc = 16'd0;
		name_len = 8'd0;
		clk_acc = 56'd0;
		frame_sum = 8'd0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_unknown_types();
		test_snap_length_error();
		test_read_empty_name();
		test_clock_bad_checksum();
		test_random_frames(230);
		test_long_name();
		test_back_to_back(100);
		rx_ch.valid <= 1'b0;

		// drain, then a short quiet window for stray beats
		while (parser_events_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d byte beats; checked %0d results:", beats_sent, events_checked);
		$display("  %0d name, %0d snap, %0d read, %0d clock", event_tally[EV_NAME],
			event_tally[EV_SNAP], event_tally[EV_READ], event_tally[EV_CLOCK]);
		$display("Error statuses seen: %0d checksum, %0d length; %0d mismatches",
			csum_err_tally, len_err_tally, mismatches);
		if (mismatches == 0)
			$display("uart_command_frame_parser verification clean");
		else
			$display("uart_command_frame_parser verification failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Timeout with %0d results outstanding", parser_events_due.size());
		$display("uart_command_frame_parser verification failed");
		$finish;
	end

endmodule

[sim.f]
sv/ucfp_pkg.sv
sv/ucfp_rx_if.sv
sv/ucfp_res_if.sv
sv/ucfp_core.sv
sv/uart_command_frame_parser.sv
tb/sv/uart_command_frame_parser_tb.sv
